### rtl/bqdw_pkg.sv
// ---------------------------------------------------------------------------
// bqdw_pkg
// Shared types, constants and helpers for the biquad dry/wet filter.
// ---------------------------------------------------------------------------
package bqdw_pkg;

    localparam int CHANNELS = 8;
    localparam int CH_AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam int SMP_W  = 16;
    localparam int COEF_W = 24;
    localparam int CH_W   = 3;
    localparam int IDX_W  = 3;
    localparam int HIST_W = 4 * SMP_W;
    localparam int MA_W   = COEF_W + 1;
    localparam int MB_W   = SMP_W + 1;
    localparam int PROD_W = MA_W + MB_W;
    localparam int ACC_W  = PROD_W + 2;
    localparam int TAPS   = 5;
    localparam int TAP_W  = $clog2(TAPS);

    localparam int GAIN_SHIFT = 14;
    localparam int FILT_SHIFT = 20;
    localparam int MIX_SHIFT  = 15;

    localparam logic signed [ACC_W-1:0] GAIN_RND = ACC_W'(1) <<< (GAIN_SHIFT - 1);
    localparam logic signed [ACC_W-1:0] FILT_RND = ACC_W'(1) <<< (FILT_SHIFT - 1);
    localparam logic signed [ACC_W-1:0] MIX_RND  = ACC_W'(1) <<< (MIX_SHIFT - 1);
    localparam logic signed [ACC_W-1:0] SAT_MAX  = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] SAT_MIN  = -ACC_W'(32768);

    localparam logic [16:0] WET_ONE = 17'd32768;

    localparam logic [IDX_W-1:0] REG_INPUT_GAIN = 3'd0;
    localparam logic [IDX_W-1:0] REG_WET_LEVEL  = 3'd1;
    localparam logic [IDX_W-1:0] REG_FF_COEF0   = 3'd2;
    localparam logic [IDX_W-1:0] REG_FF_COEF1   = 3'd3;
    localparam logic [IDX_W-1:0] REG_FF_COEF2   = 3'd4;
    localparam logic [IDX_W-1:0] REG_FB_COEF1   = 3'd5;
    localparam logic [IDX_W-1:0] REG_FB_COEF2   = 3'd6;

    localparam logic [15:0]       GAIN_RESET = 16'd16384;
    localparam logic [15:0]       WET_RESET  = 16'd32768;
    localparam logic [COEF_W-1:0] FF0_RESET  = 24'd1048576;

    typedef enum logic [3:0] {
        S_IDLE,
        S_GAIN,
        S_XSAT,
        S_MAC,
        S_ACCL,
        S_YSAT,
        S_MIX1,
        S_MIX2,
        S_DONE
    } bqdw_state_t;

    function automatic logic signed [SMP_W-1:0] sat16(input logic signed [ACC_W-1:0] v);
        logic signed [SMP_W-1:0] r;
        if (v > SAT_MAX)
            r = SAT_MAX[SMP_W-1:0];
        else if (v < SAT_MIN)
            r = SAT_MIN[SMP_W-1:0];
        else
            r = v[SMP_W-1:0];
        return r;
    endfunction

endpackage

### rtl/bqdw_ram.sv
// ---------------------------------------------------------------------------
// bqdw_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module bqdw_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/biquad_filter_dry_wet.sv
// ---------------------------------------------------------------------------
// biquad_filter_dry_wet
// Multi-channel direct form I biquad with input gain and dry/wet mix.
// ---------------------------------------------------------------------------
// in_ready is high only in S_IDLE, so a new item is accepted only after the last
// one has left S_DONE, which holds while the previous output is not taken. A single
// shared 25x17 multiplier forms the eight products (gain, five taps, two mix terms).
// History lives in one RAM word per channel, read once and written once.
// Reset loads the register defaults and clears the per-channel valid bits,
// so every channel starts from zero history.
module biquad_filter_dry_wet
    import bqdw_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [IDX_W-1:0]         cfg_addr,
    input  logic [COEF_W-1:0]        cfg_wdata,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [CH_W-1:0]          channel_in,
    input  logic signed [SMP_W-1:0]  sample_in,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [CH_W-1:0]          channel_out,
    output logic signed [SMP_W-1:0]  sample_out
);

    bqdw_state_t state_reg, state_next;

    logic [15:0]              gain_reg;
    logic [15:0]              wet_reg;
    logic signed [COEF_W-1:0] coef_reg [TAPS];

    logic [CHANNELS-1:0]      hist_vld_reg;
    logic [CH_W-1:0]          ch_reg;
    logic                     ch_ok_reg;
    logic                     hit_reg;
    logic signed [SMP_W-1:0]  smp_reg;
    logic signed [SMP_W-1:0]  x_reg, x1_reg, x2_reg, y_reg, y1_reg, y2_reg;
    logic [TAP_W-1:0]         tap_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     neg_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic                     out_valid_reg;
    logic [CH_W-1:0]          channel_out_reg;
    logic signed [SMP_W-1:0]  sample_out_reg;

    logic                     accept;
    logic                     out_free;
    logic                     ram_we;
    logic                     ch_ok;
    logic [CH_AW-1:0]         rd_addr;
    logic [CH_AW-1:0]         wr_addr;
    logic [HIST_W-1:0]        ram_rdata;
    logic [HIST_W-1:0]        ram_wdata;
    logic [16:0]              wet_eff;
    logic [16:0]              dry_w;
    logic signed [MA_W-1:0]   mul_a;
    logic signed [MB_W-1:0]   mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [ACC_W-1:0]  prod_ext;
    logic signed [ACC_W-1:0]  acc_sum;
    logic signed [SMP_W-1:0]  tap_op [TAPS];

    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign ch_ok    = (32'(channel_in) < CHANNELS);
    assign rd_addr  = CH_AW'(channel_in);
    assign wr_addr  = CH_AW'(ch_reg);
    assign ram_wdata = {x_reg, x1_reg, y_reg, y1_reg};

    assign wet_eff = (wet_reg > WET_ONE[15:0] && wet_reg != 16'd0) ? WET_ONE : {1'b0, wet_reg};
    assign dry_w   = WET_ONE - wet_eff;

    assign tap_op[0] = x_reg;
    assign tap_op[1] = x1_reg;
    assign tap_op[2] = x2_reg;
    assign tap_op[3] = y1_reg;
    assign tap_op[4] = y2_reg;

    assign prod_ext = ACC_W'(prod_reg);
    assign acc_sum  = neg_reg ? (acc_reg - prod_ext) : (acc_reg + prod_ext);

    bqdw_ram #(
        .WIDTH (HIST_W),
        .DEPTH (CHANNELS)
    ) u_hist_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_addr),
        .wdata (ram_wdata),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_GAIN:
            begin
                mul_a = MA_W'($signed({1'b0, gain_reg}));
                mul_b = MB_W'(smp_reg);
            end
            S_MAC:
            begin
                mul_a = MA_W'(coef_reg[tap_reg]);
                mul_b = MB_W'(tap_op[tap_reg]);
            end
            S_ACCL:
            begin
                mul_a = MA_W'($signed({1'b0, dry_w}));
                mul_b = MB_W'(x_reg);
            end
            S_MIX1:
            begin
                mul_a = MA_W'($signed({1'b0, wet_eff}));
                mul_b = MB_W'(y_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_GAIN;
            end
            S_GAIN:  state_next = S_XSAT;
            S_XSAT:  state_next = S_MAC;
            S_MAC:
            begin
                if (tap_reg == TAP_W'(TAPS - 1))
                    state_next = S_ACCL;
            end
            S_ACCL:  state_next = S_YSAT;
            S_YSAT:  state_next = S_MIX1;
            S_MIX1:  state_next = S_MIX2;
            S_MIX2:  state_next = S_DONE;
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        in_ready = 1'b0;
        ram_we   = 1'b0;
        case (state_reg)
            S_IDLE:  in_ready = 1'b1;
            S_DONE:  ram_we   = out_free && ch_ok_reg;
            default:
            begin
                in_ready = 1'b0;
                ram_we   = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            hist_vld_reg  <= '0;
            gain_reg      <= GAIN_RESET;
            wet_reg       <= WET_RESET;
            coef_reg[0]   <= FF0_RESET;
            coef_reg[1]   <= '0;
            coef_reg[2]   <= '0;
            coef_reg[3]   <= '0;
            coef_reg[4]   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_INPUT_GAIN: gain_reg    <= cfg_wdata[15:0];
                    REG_WET_LEVEL:  wet_reg     <= cfg_wdata[15:0];
                    REG_FF_COEF0:   coef_reg[0] <= cfg_wdata;
                    REG_FF_COEF1:   coef_reg[1] <= cfg_wdata;
                    REG_FF_COEF2:   coef_reg[2] <= cfg_wdata;
                    REG_FB_COEF1:   coef_reg[3] <= cfg_wdata;
                    REG_FB_COEF2:   coef_reg[4] <= cfg_wdata;
                    default:        ;
                endcase
            end
            if (ram_we)
                hist_vld_reg[wr_addr] <= 1'b1;
            if (state_reg == S_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    ch_reg    <= channel_in;
                    smp_reg   <= sample_in;
                    ch_ok_reg <= ch_ok;
                    hit_reg   <= ch_ok && hist_vld_reg[rd_addr];
                end
            end
            S_GAIN:
            begin
                prod_reg <= mul_p;
                if (hit_reg)
                    {x1_reg, x2_reg, y1_reg, y2_reg} <= ram_rdata;
                else
                    {x1_reg, x2_reg, y1_reg, y2_reg} <= '0;
            end
            S_XSAT:
            begin
                x_reg   <= sat16((prod_ext + GAIN_RND) >>> GAIN_SHIFT);
                acc_reg <= '0;
                tap_reg <= '0;
            end
            S_MAC:
            begin
                prod_reg <= mul_p;
                neg_reg  <= (tap_reg >= TAP_W'(3));
                if (tap_reg != '0)
                    acc_reg <= acc_sum;
                tap_reg <= tap_reg + TAP_W'(1);
            end
            S_ACCL:
            begin
                acc_reg  <= acc_sum;
                prod_reg <= mul_p;
                neg_reg  <= 1'b0;
            end
            S_YSAT:
            begin
                y_reg   <= sat16((acc_reg + FILT_RND) >>> FILT_SHIFT);
                acc_reg <= prod_ext;
            end
            S_MIX1:
            begin
                prod_reg <= mul_p;
            end
            S_MIX2:
            begin
                acc_reg <= acc_sum;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    channel_out_reg <= ch_reg;
                    sample_out_reg  <= sat16((acc_reg + MIX_RND) >>> MIX_SHIFT);
                end
            end
            default: ;
        endcase
    end

    assign out_valid   = out_valid_reg;
    assign channel_out = channel_out_reg;
    assign sample_out  = sample_out_reg;

endmodule
